@@ rtl/core/tbo_pkg.sv @@
// Shared constants for the triangle / box overlap block.
// Holds register indexes and default widths; no dependencies.
package tbo_pkg;

   // Default coordinate width (signed fixed point, 8 fraction bits).
   localparam int COORD_WIDTH_DEF = 24;

   // Register map: one 32-bit word per register.
   localparam int NUM_REGS  = 6;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_HALF_X   = 3'd3,
      REG_HALF_Y   = 3'd4,
      REG_HALF_Z   = 3'd5
   } reg_index_type;

endpackage

@@ rtl/core/tbo_csr.sv @@
// Configuration registers of the overlap block: box center and half sizes.
// Depends on tbo_pkg for the register map.
module tbo_csr import tbo_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready,
   output logic [2:0][COORD_WIDTH-1:0]   center,
   output logic [2:0][COORD_WIDTH-2:0]   half
);

   logic [2:0][COORD_WIDTH-1:0] center_ff, center_in;
   logic [2:0][COORD_WIDTH-2:0] half_ff, half_in;
   logic                        wr_en;
   reg_index_type               idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   // Register write decode; addresses past the map are ignored.
   always_comb begin
      center_in = center_ff;
      half_in   = half_ff;
      if (wr_en) begin
         unique case (idx)
            REG_CENTER_X: center_in[0] = pwdata[COORD_WIDTH-1:0];
            REG_CENTER_Y: center_in[1] = pwdata[COORD_WIDTH-1:0];
            REG_CENTER_Z: center_in[2] = pwdata[COORD_WIDTH-1:0];
            REG_HALF_X:   half_in[0]   = pwdata[COORD_WIDTH-2:0];
            REG_HALF_Y:   half_in[1]   = pwdata[COORD_WIDTH-2:0];
            REG_HALF_Z:   half_in[2]   = pwdata[COORD_WIDTH-2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         half_ff   <= '0;
      end else begin
         center_ff <= center_in;
         half_ff   <= half_in;
      end
   end

   // Read data, zero extended.
   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_CENTER_X: prdata = CSR_DATA_W'(center_ff[0]);
         REG_CENTER_Y: prdata = CSR_DATA_W'(center_ff[1]);
         REG_CENTER_Z: prdata = CSR_DATA_W'(center_ff[2]);
         REG_HALF_X:   prdata = CSR_DATA_W'(half_ff[0]);
         REG_HALF_Y:   prdata = CSR_DATA_W'(half_ff[1]);
         REG_HALF_Z:   prdata = CSR_DATA_W'(half_ff[2]);
         default:      prdata = '0;
      endcase
   end

   assign center = center_ff;
   assign half   = half_ff;

endmodule

@@ rtl/core/tbo_datapath.sv @@
// Pipelined separating-axis datapath: eight register stages from vertices to flag.
// Depends on tbo_pkg for the default coordinate width.
module tbo_datapath import tbo_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [2:0][2:0][COORD_WIDTH-1:0]   vert,
   input  logic [2:0][COORD_WIDTH-1:0]        center,
   input  logic [2:0][COORD_WIDTH-2:0]        half,
   output logic                               out_valid,
   output logic                               out_overlap
);

   localparam int W    = COORD_WIDTH;
   localparam int VW   = W + 1;          // vertex relative to center
   localparam int EW   = W + 2;          // edge
   localparam int HW   = W - 1;          // half size
   localparam int PW   = EW + VW;        // edge-axis product
   localparam int PD   = PW + 1;         // edge-axis projection
   localparam int RW   = EW + HW + 1;    // edge-axis radius
   localparam int CW   = PD + 1;         // edge-axis compare width
   localparam int NW   = 2 * EW + 1;     // normal component
   localparam int NL   = NW / 2;         // low slice of a normal component
   localparam int NH   = NW - NL;        // high slice
   localparam int DP   = NW + VW;        // normal times vertex
   localparam int DW   = DP + 2;         // plane distance
   localparam int RP   = NW + HW;        // |normal| times half size
   localparam int PRW  = RP + 2;         // plane radius
   localparam int NT   = 9;              // edge-axis tests

   // Valid bits, one per stage.
   logic [7:0] vld_ff;

   // Stage 1: vertices relative to the center.
   logic signed [VW-1:0] v1_ff [3][3];
   logic signed [VW-1:0] v1_in [3][3];
   // Stage 2: edges.
   logic signed [VW-1:0] v2_ff [3][3];
   logic signed [EW-1:0] e2_ff [3][3];
   logic signed [EW-1:0] e2_in [3][3];
   // Stage 3: products.
   logic signed [PW-1:0] m1_ff [NT][3];
   logic signed [PW-1:0] m2_ff [NT][3];
   logic signed [PW-1:0] m1_in [NT][3];
   logic signed [PW-1:0] m2_in [NT][3];
   logic [RW-2:0]        ra_ff [NT];
   logic [RW-2:0]        rb_ff [NT];
   logic [RW-2:0]        ra_in [NT];
   logic [RW-2:0]        rb_in [NT];
   logic signed [NW-2:0] na_ff [3];
   logic signed [NW-2:0] nb_ff [3];
   logic signed [NW-2:0] na_in [3];
   logic signed [NW-2:0] nb_in [3];
   logic signed [VW-1:0] v3_ff [3];
   logic [2:0]           bx3_ff, bx3_in;
   // Stage 4: projections, radii and normal.
   logic signed [PD-1:0] p4_ff [NT][3];
   logic signed [PD-1:0] p4_in [NT][3];
   logic [RW-1:0]        r4_ff [NT];
   logic [RW-1:0]        r4_in [NT];
   logic signed [NW-1:0] n4_ff [3];
   logic signed [NW-1:0] n4_in [3];
   logic [NW-1:0]        na4_ff [3];
   logic [NW-1:0]        na4_in [3];
   logic signed [VW-1:0] v4_ff [3];
   logic [2:0]           bx4_ff;
   // Stage 5: edge-axis verdicts and partial products of the plane test.
   logic                 sep5_ff, sep5_in;
   logic signed [NL+VW:0]   dlo_ff [3];
   logic signed [NL+VW:0]   dlo_in [3];
   logic signed [NH+VW-1:0] dhi_ff [3];
   logic signed [NH+VW-1:0] dhi_in [3];
   logic [NL+HW-1:0]        rlo_ff [3];
   logic [NL+HW-1:0]        rlo_in [3];
   logic [NH+HW-1:0]        rhi_ff [3];
   logic [NH+HW-1:0]        rhi_in [3];
   // Stage 6: full products.
   logic                 sep6_ff;
   logic signed [DP-1:0] dp_ff [3];
   logic signed [DP-1:0] dp_in [3];
   logic [RP-1:0]        rp_ff [3];
   logic [RP-1:0]        rp_in [3];
   // Stage 7: sums.
   logic                 sep7_ff;
   logic signed [DW-1:0] ds_ff, ds_in;
   logic [PRW-1:0]       rs_ff, rs_in;
   // Stage 8: result.
   logic                 ovl_ff, ovl_in;
   logic [DW-1:0]        adist;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   // Stage 1 logic: subtract the box center.
   always_comb begin
      for (int q = 0; q < 3; q++) begin
         for (int k = 0; k < 3; k++) begin
            v1_in[q][k] = $signed({vert[q][k][W-1], vert[q][k]})
                        - $signed({center[k][W-1], center[k]});
         end
      end
   end

   // Stage 2 logic: form the triangle edges, each one vertex minus the previous one.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e2_in[0][k] = EW'(v1_ff[1][k]) - EW'(v1_ff[0][k]);
         e2_in[1][k] = EW'(v1_ff[2][k]) - EW'(v1_ff[1][k]);
         e2_in[2][k] = EW'(v1_ff[0][k]) - EW'(v1_ff[2][k]);
      end
   end

   // Stage 3 logic: edge-axis products, normal products, box-axis tests.
   always_comb begin
      logic signed [EW-1:0] ei, ej;
      logic [EW-1:0]        ai, aj;
      logic signed [VW:0]   pv, rad;
      logic                 above, below;
      int                   i, j;
      for (int t = 0; t < 3; t++) begin
         for (int k = 0; k < 3; k++) begin
            i  = (k + 1) % 3;
            j  = (k + 2) % 3;
            ei = e2_ff[t][i];
            ej = e2_ff[t][j];
            ai = ei[EW-1] ? EW'(-ei) : EW'(ei);
            aj = ej[EW-1] ? EW'(-ej) : EW'(ej);
            for (int q = 0; q < 3; q++) begin
               m1_in[t*3+k][q] = ej * v2_ff[q][i];
               m2_in[t*3+k][q] = ei * v2_ff[q][j];
            end
            ra_in[t*3+k] = (RW-1)'(aj * half[i]);
            rb_in[t*3+k] = (RW-1)'(ai * half[j]);
         end
      end
      for (int k = 0; k < 3; k++) begin
         i = (k + 1) % 3;
         j = (k + 2) % 3;
         na_in[k] = e2_ff[0][i] * e2_ff[1][j];
         nb_in[k] = e2_ff[0][j] * e2_ff[1][i];
      end
      // Box axes: separated when all three vertices lie strictly beyond one face.
      for (int k = 0; k < 3; k++) begin
         rad   = $signed({2'b00, half[k]});
         above = 1'b1;
         below = 1'b1;
         for (int q = 0; q < 3; q++) begin
            pv    = (VW+1)'(v2_ff[q][k]);
            above = above && (pv > rad);
            below = below && (pv < -rad);
         end
         bx3_in[k] = above || below;
      end
   end

   // Stage 4 logic: projections, radii, normal and its magnitude.
   always_comb begin
      for (int t = 0; t < NT; t++) begin
         for (int q = 0; q < 3; q++) begin
            p4_in[t][q] = PD'(m1_ff[t][q]) - PD'(m2_ff[t][q]);
         end
         r4_in[t] = RW'(ra_ff[t]) + RW'(rb_ff[t]);
      end
      for (int k = 0; k < 3; k++) begin
         n4_in[k]  = NW'(na_ff[k]) - NW'(nb_ff[k]);
         na4_in[k] = n4_in[k][NW-1] ? NW'(-n4_in[k]) : NW'(n4_in[k]);
      end
   end

   // Stage 5 logic: edge-axis verdicts merged with the box-axis ones, and sliced plane products.
   always_comb begin
      logic signed [CW-1:0] pv, rad;
      logic                 above, below;
      sep5_in = |bx4_ff;
      for (int t = 0; t < NT; t++) begin
         rad   = $signed({{(CW-RW){1'b0}}, r4_ff[t]});
         above = 1'b1;
         below = 1'b1;
         for (int q = 0; q < 3; q++) begin
            pv    = CW'(p4_ff[t][q]);
            above = above && (pv > rad);
            below = below && (pv < -rad);
         end
         sep5_in = sep5_in || above || below;
      end
      for (int k = 0; k < 3; k++) begin
         dlo_in[k] = $signed({1'b0, n4_ff[k][NL-1:0]}) * v4_ff[k];
         dhi_in[k] = $signed(n4_ff[k][NW-1:NL]) * v4_ff[k];
         rlo_in[k] = na4_ff[k][NL-1:0] * half[k];
         rhi_in[k] = na4_ff[k][NW-1:NL] * half[k];
      end
   end

   // Stage 6 logic: recombine the slices.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dp_in[k] = (DP'(dhi_ff[k]) <<< NL) + DP'(dlo_ff[k]);
         rp_in[k] = (RP'(rhi_ff[k]) << NL) + RP'(rlo_ff[k]);
      end
   end

   // Stage 7 logic: plane distance and plane radius.
   always_comb begin
      ds_in = DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);
      rs_in = PRW'(rp_ff[0]) + PRW'(rp_ff[1]) + PRW'(rp_ff[2]);
   end

   // Stage 8 logic: touching counts as overlap.
   always_comb begin
      adist  = ds_ff[DW-1] ? DW'(-ds_ff) : DW'(ds_ff);
      ovl_in = !sep7_ff && ((DW+1)'(adist) <= (DW+1)'(rs_ff));
   end

   // Pipeline registers; payload needs no reset.
   always_ff @(posedge clock) begin
      v1_ff   <= v1_in;
      v2_ff   <= v1_ff;
      e2_ff   <= e2_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      na_ff   <= na_in;
      nb_ff   <= nb_in;
      v3_ff   <= v2_ff[0];
      bx3_ff  <= bx3_in;
      p4_ff   <= p4_in;
      r4_ff   <= r4_in;
      n4_ff   <= n4_in;
      na4_ff  <= na4_in;
      v4_ff   <= v3_ff;
      bx4_ff  <= bx3_ff;
      sep5_ff <= sep5_in;
      dlo_ff  <= dlo_in;
      dhi_ff  <= dhi_in;
      rlo_ff  <= rlo_in;
      rhi_ff  <= rhi_in;
      sep6_ff <= sep5_ff;
      dp_ff   <= dp_in;
      rp_ff   <= rp_in;
      sep7_ff <= sep6_ff;
      ds_ff   <= ds_in;
      rs_ff   <= rs_in;
      ovl_ff  <= ovl_in;
   end

   assign out_valid   = vld_ff[7];
   assign out_overlap = ovl_ff;

endmodule

@@ rtl/core/triangle_box_overlap.sv @@
// Triangle / axis-aligned box overlap test, separating-axis method.
// Results: rsp_valid and rsp_overlap leave the last register stage of the
// datapath together. The receiver cannot stall.
// Throughput: one triangle per cycle; busy is never raised, as the
// eight-stage datapath takes a new item every cycle.
// Reset clears the box registers to zero and drops all items in flight.
module triangle_box_overlap import tbo_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_a_x,
   input  logic [COORD_WIDTH-1:0] req_a_y,
   input  logic [COORD_WIDTH-1:0] req_a_z,
   input  logic [COORD_WIDTH-1:0] req_b_x,
   input  logic [COORD_WIDTH-1:0] req_b_y,
   input  logic [COORD_WIDTH-1:0] req_b_z,
   input  logic [COORD_WIDTH-1:0] req_c_x,
   input  logic [COORD_WIDTH-1:0] req_c_y,
   input  logic [COORD_WIDTH-1:0] req_c_z,
   output logic                   rsp_valid,
   output logic                   rsp_overlap,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   logic [2:0][COORD_WIDTH-1:0]      center;
   logic [2:0][COORD_WIDTH-2:0]      half;
   logic [2:0][2:0][COORD_WIDTH-1:0] vert;

   assign busy = 1'b0;

   assign vert[0] = {req_a_z, req_a_y, req_a_x};
   assign vert[1] = {req_b_z, req_b_y, req_b_x};
   assign vert[2] = {req_c_z, req_c_y, req_c_x};

   // Box configuration registers.
   tbo_csr #(.COORD_WIDTH(COORD_WIDTH)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .center  (center),
      .half    (half)
   );

   // Overlap pipeline.
   tbo_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start && !busy),
      .vert        (vert),
      .center      (center),
      .half        (half),
      .out_valid   (rsp_valid),
      .out_overlap (rsp_overlap)
   );

endmodule
